// ===== hdl/dwr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dwr_pkg: shared types and ring arithmetic for the reversible deque
// Holds the ring size, the derived widths, the operation codes and the
// modulo helper that moves a ring position in either orientation.
// ----------------------------------------------------------------------------
package dwr_pkg;

  // Ring size and derived widths.
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W   = CNT_W + 1;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operation codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_HEAD = 2'd0,
    KIND_PUSH_TAIL = 2'd1,
    KIND_POP_HEAD  = 2'd2,
    KIND_REVERSE   = 2'd3
  } kind_t;

  // Position k steps after a in the given orientation, with k below DEPTH.
  // The sum stays below twice the ring size, so one conditional subtract
  // brings it back into range.
  function automatic idx_t ring_step(idx_t a, cnt_t k, logic backwards);
    logic [SUM_W-1:0] s;
    if (backwards) begin
      s = SUM_W'(a) + SUM_W'(DEPTH) - SUM_W'(k);
    end else begin
      s = SUM_W'(a) + SUM_W'(k);
    end
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/deque_with_reverse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deque_with_reverse: bounded double-ended queue with constant-time reversal
// Signed 32-bit values in a ring held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, kind, value) carries one operation
//   per beat: insert at head, insert at tail, remove from head, or reverse.
//   The output channel (out_valid, out_ready, ok, removed_value, count)
//   returns exactly one result beat per operation, in order.
//   A result appears in the cycle after its operation is accepted.
//   Throughput is one operation per cycle while the receiver takes each
//   result, set by the at most one memory access (a write or a read) per operation.
//   A remove reads the slot at the accept edge; the registered memory output
//   then forms removed_value, so no forwarding is needed between a write and
//   a later read of the same slot.
//   Reversing a non-empty queue flips the orientation flag and moves the
//   head pointer to the old tail; no slot is touched.
//   Reset empties the queue and clears the orientation; slot contents stay
//   undefined, which is harmless as only written slots are ever removed.
//   While the receiver stalls with a result pending, in_ready is low and the
//   result is held unchanged.
// ----------------------------------------------------------------------------
module deque_with_reverse (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [dwr_pkg::KIND_W-1:0]         kind,
  input  wire logic signed [dwr_pkg::VALUE_W-1:0] value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    ok,
  output logic signed [dwr_pkg::VALUE_W-1:0]      removed_value,
  output logic [dwr_pkg::COUNT_W-1:0]             count
);
  import dwr_pkg::*;

  // Ring storage and pointers.
  logic [VALUE_W-1:0] slots [DEPTH];
  logic [VALUE_W-1:0] rd_data;
  idx_t               front;
  idx_t               front_next;
  cnt_t               occupancy;
  cnt_t               occupancy_next;
  logic               reversed;
  logic               reversed_next;

  // Per-operation decode.
  kind_t              op;
  logic               accept;
  logic               full;
  logic               empty;
  logic               op_ok;
  logic               wr_en;
  idx_t               wr_addr;
  logic               rd_en;
  logic               popped;

  assign op       = kind_t'(kind);
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (occupancy == CNT_W'(DEPTH));
  assign empty    = (occupancy == '0);

  // Work out the pointer update and the memory access for this operation.
  always_comb begin
    front_next     = front;
    occupancy_next = occupancy;
    reversed_next  = reversed;
    op_ok          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = front;
    rd_en          = 1'b0;
    unique case (op)
      KIND_PUSH_HEAD: begin
        if (!full) begin
          front_next     = ring_step(front, CNT_W'(1), !reversed);
          wr_addr        = front_next;
          wr_en          = 1'b1;
          occupancy_next = occupancy + CNT_W'(1);
          op_ok          = 1'b1;
        end
      end
      KIND_PUSH_TAIL: begin
        if (!full) begin
          wr_addr        = ring_step(front, occupancy, reversed);
          wr_en          = 1'b1;
          occupancy_next = occupancy + CNT_W'(1);
          op_ok          = 1'b1;
        end
      end
      KIND_POP_HEAD: begin
        if (!empty) begin
          rd_en          = 1'b1;
          front_next     = ring_step(front, CNT_W'(1), reversed);
          occupancy_next = occupancy - CNT_W'(1);
          op_ok          = 1'b1;
        end
      end
      KIND_REVERSE: begin
        op_ok = 1'b1;
        if (!empty) begin
          front_next    = ring_step(front, occupancy - CNT_W'(1), reversed);
          reversed_next = !reversed;
        end
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // Control state and the result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      occupancy <= '0;
      reversed  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        front     <= front_next;
        occupancy <= occupancy_next;
        reversed  <= reversed_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      ok     <= op_ok;
      popped <= rd_en;
      count  <= COUNT_W'(occupancy_next);
    end
  end

  // Slot memory: at most one write or one registered read per accepted beat.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      slots[wr_addr] <= value;
    end
    if (accept && rd_en) begin
      rd_data <= slots[front];
    end
  end

  assign removed_value = popped ? rd_data : '0;

`ifndef SYNTHESIS
  // The element count never passes the ring size.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(DEPTH))
    else $error("occupancy exceeds ring size");

  // A pending result that is not taken blocks new operations.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // A remove from an empty queue fails and leaves the count alone.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    accept && op == KIND_POP_HEAD && empty |=> !ok && removed_value == '0
      && $stable(occupancy))
    else $error("remove from empty queue misreported");

  // An insert into a full queue fails and the queue stays full.
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    accept && (op == KIND_PUSH_HEAD || op == KIND_PUSH_TAIL) && full
      |=> !ok && full)
    else $error("insert into full queue misreported");

  // Reversal always succeeds and keeps the count.
  a_reverse: assert property (@(posedge clk) disable iff (rst)
    accept && op == KIND_REVERSE |=> ok && $stable(occupancy))
    else $error("reverse misreported");
`endif

endmodule
`default_nettype wire
